// ===== sv/rmed_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmed_pkg: shared types for the running median unit
// Sequencer states for the sorted insertion and the median fetch.
// ----------------------------------------------------------------------------
package rmed_pkg;

   // Sequencer states, one-hot
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SHIFT = 5'b00010,
      ST_RDLO  = 5'b00100,
      ST_RDHI  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

endpackage : rmed_pkg
`default_nettype wire

// ===== sv/rmed_stream_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmed_stream_if: valid/ready channel with a generic payload
// One beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rmed_stream_if #(
   parameter int Width = 17
) ();
   logic             valid;
   logic             ready;
   logic [Width-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface : rmed_stream_if
`default_nettype wire

// ===== sv/running_median_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// running_median_unit: streaming median over a sorted store
// ----------------------------------------------------------------------------
// Each request beat carries a signed sample and a restart flag; one response
// beat returns the median of all samples held, the count and a rejected
// flag. Samples live in one sorted memory. An insertion compares the new
// sample against stored entries from the top down, one entry per cycle,
// shifting larger ones up. After the insertion an odd count fetches one
// middle entry, and an even count fetches two middles and averages them.
// A rejected item answers at the next edge. The next request is taken
// only once the sequencer is idle and the response has been accepted, so
// one item is handled at a time. The single memory read port and the one
// compare keep the insertion serial. The store needs no clearing pass;
// only entries below the count are read.
// ----------------------------------------------------------------------------
module running_median_unit #(
   parameter int Capacity    = 64,
   parameter int SampleWidth = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   rmed_stream_if.sink   req,
   rmed_stream_if.source rsp
);
   import rmed_pkg::*;

   localparam int AddrWidth  = (Capacity > 1) ? $clog2(Capacity) : 1;
   localparam int CountWidth = $clog2(Capacity + 1);

   state_type state_ff, state_in;
   logic [CountWidth-1:0]         count_ff, count_in;
   logic [CountWidth-1:0]         pos_ff, pos_in;
   logic signed [SampleWidth-1:0] x_ff, x_in;
   logic signed [SampleWidth-1:0] med_ff, med_in;
   logic signed [SampleWidth-1:0] lo_ff, lo_in;
   logic                          rej_ff, rej_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          pend_ff, pend_in;

   logic                          rd_en, wr_en;
   logic [AddrWidth-1:0]          rd_addr, wr_addr;
   logic signed [SampleWidth-1:0] rd_data, wr_data;
   logic signed [SampleWidth:0]   sum;
   logic [CountWidth-1:0]         half;
   logic                          req_fire;
   logic signed [SampleWidth-1:0] req_sample;
   logic                          req_restart;
   logic [CountWidth-1:0]         base;

   assign req_sample  = req.data[SampleWidth-1:0];
   assign req_restart = req.data[SampleWidth];
   assign req.ready   = state_ff == ST_IDLE && !rsp_valid_ff;
   assign req_fire    = req.valid && req.ready;
   assign half        = count_ff >> 1;
   assign sum         = {lo_ff[SampleWidth-1], lo_ff} + {rd_data[SampleWidth-1], rd_data};

   rmed_store #(
      .Capacity(Capacity), .SampleWidth(SampleWidth), .AddrWidth(AddrWidth)
   ) u_store (
      .clock, .rd_en, .rd_addr, .rd_data, .wr_en, .wr_addr, .wr_data
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      x_in         = x_ff;
      med_in       = med_ff;
      lo_in        = lo_ff;
      rej_in       = rej_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = x_ff;
      base         = req_restart ? '0 : count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               x_in = req_sample;
               if (base == CountWidth'(Capacity)) begin
                  rej_in       = 1'b1;
                  rsp_valid_in = 1'b1;
               end else begin
                  rej_in   = 1'b0;
                  count_in = base;
                  pos_in   = base;
                  state_in = ST_SHIFT;
                  // prefetch the entry below the slot
                  pend_in  = base != '0;
                  rd_en    = base != '0;
                  rd_addr  = AddrWidth'(base - 1'b1);
               end
            end
         end
         ST_SHIFT: begin
            // rd_data holds entry pos-1 when pend is set
            if (pend_ff && rd_data > x_ff) begin
               wr_en   = 1'b1;
               wr_addr = AddrWidth'(pos_ff);
               wr_data = rd_data;
               pos_in  = pos_ff - 1'b1;
               pend_in = pos_ff != 1;
               rd_en   = pos_ff != 1;
               rd_addr = AddrWidth'(pos_ff - 2'd2);
            end else begin
               wr_en    = 1'b1;
               wr_addr  = AddrWidth'(pos_ff);
               wr_data  = x_ff;
               count_in = count_ff + 1'b1;
               state_in = ST_RDLO;
            end
         end
         ST_RDLO: begin
            // odd: middle at half; even: half-1 then half
            rd_en    = 1'b1;
            rd_addr  = count_ff[0] ? AddrWidth'(half) : AddrWidth'(half - 1'b1);
            state_in = ST_RDHI;
         end
         ST_RDHI: begin
            rd_en    = 1'b1;
            rd_addr  = AddrWidth'(half);
            lo_in    = rd_data;
            state_in = ST_DONE;
            if (count_ff[0]) begin
               med_in       = rd_data;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_DONE: begin
            // truncate toward zero
            med_in       = SampleWidth'((sum + SampleWidth'(sum[SampleWidth])) >>> 1);
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         med_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         rej_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         med_ff       <= med_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         rej_ff       <= rej_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      x_ff   <= x_in;
      lo_ff  <= lo_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = {rej_ff, 7'(count_ff), med_ff};

   // checks
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(Capacity))
      else $error("count above capacity");
   a_rej_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rej_ff |-> count_ff == CountWidth'(Capacity))
      else $error("reject with room left");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !rsp_valid_ff)
      else $error("response while busy");
endmodule : running_median_unit
`default_nettype wire

// ===== sv/rmed_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmed_store: sorted sample memory; the compare is in running_median_unit
// Insertion walks down from the top, one entry a cycle, moving larger
// entries up one; a registered read port feeds the walk and the median fetch.
// ----------------------------------------------------------------------------
module rmed_store #(
   parameter int Capacity    = 64,
   parameter int SampleWidth = 16,
   parameter int AddrWidth   = 6
) (
   input  wire logic                          clock,
   input  wire logic                          rd_en,
   input  wire logic [AddrWidth-1:0]          rd_addr,
   output logic signed [SampleWidth-1:0]      rd_data,
   input  wire logic                          wr_en,
   input  wire logic [AddrWidth-1:0]          wr_addr,
   input  wire logic signed [SampleWidth-1:0] wr_data
);
   logic signed [SampleWidth-1:0] mem [Capacity];

   // single write port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) rd_data <= mem[rd_addr];
   end
endmodule : rmed_store
`default_nettype wire

// ===== tb/tb_stream_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_stream_if: testbench-side note for the stream channel
// The channel itself is the design's rmed_stream_if; this file only holds the
// beat layouts that the testbench uses on both channels.
// ----------------------------------------------------------------------------
package tb_beat_pkg;

   // Request beat: restart flag on top, sample in the low 16 bits
   typedef struct packed {
      logic               restart;
      logic signed [15:0] sample;
   } req_beat_type;

   // Response beat: rejected flag, stored count, median in the low bits
   typedef struct packed {
      logic               rejected;
      logic [6:0]         stored_count;
      logic signed [15:0] median;
   } rsp_beat_type;

endpackage : tb_beat_pkg
`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb: self-checking bench for running_median_unit
// Drives samples with restart flags through the request channel, predicts
// each median from a sorted copy of the store, and checks every response
// beat in order under random gaps and back-pressure.
// ----------------------------------------------------------------------------
module tb;
   import tb_beat_pkg::*;

   localparam int Capacity = 64;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rmed_stream_if #(.Width(17)) req_if ();
   rmed_stream_if #(.Width(24)) rsp_if ();

   running_median_unit #(.Capacity(Capacity), .SampleWidth(16)) DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source)
   );

   always #6 clock = ~clock;

   // predictor state
   logic signed [15:0] sorted_store [Capacity];
   int                 held_count = 0;
   logic signed [15:0] held_median = '0;
   rsp_beat_type       pending_medians[$];

   int  mismatch_count = 0;
   int  stall_left = 0;
   bit  quiet = 1'b0;
   bit  sender_gaps = 1'b1;

   initial begin
      req_if.valid = 1'b0;
      req_if.data  = '0;
      rsp_if.ready = 1'b0;
   end

   // gap length: mostly short, now and then long
   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   // expected response for one accepted beat
   function automatic rsp_beat_type predict_median(req_beat_type beat);
      rsp_beat_type r;
      int           pos;
      int           pair_sum;
      r.rejected = 1'b0;
      if (beat.restart) held_count = 0;
      if (held_count >= Capacity) begin
         r.rejected = 1'b1;
      end else begin
         pos = held_count;
         while (pos > 0 && sorted_store[pos-1] > beat.sample) begin
            sorted_store[pos] = sorted_store[pos-1];
            pos--;
         end
         sorted_store[pos] = beat.sample;
         held_count++;
         if (held_count % 2 == 1) begin
            held_median = sorted_store[(held_count-1)/2];
         end else begin
            pair_sum = int'(sorted_store[held_count/2-1]) + int'(sorted_store[held_count/2]);
            held_median = 16'(pair_sum / 2);
         end
      end
      r.median       = held_median;
      r.stored_count = 7'(held_count);
      return r;
   endfunction

   // send one beat; valid stays high across back-to-back beats
   task automatic send_sample(input logic signed [15:0] sample, input logic restart);
      req_beat_type beat;
      int           gap;
      beat.sample  = sample;
      beat.restart = restart;
      req_if.valid <= 1'b1;
      req_if.data  <= beat;
      do @(posedge clock); while (!req_if.ready);
      pending_medians = {pending_medians, predict_median(beat)};
      gap = (sender_gaps && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (pending_medians.size() != 0) @(posedge clock);
   endtask

   // response back-pressure
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_if.ready <= 1'b1;
         if (!quiet && $urandom_range(0, 5) == 0) stall_left <= pick_gap();
      end
   end

   // response checker
   always @(posedge clock) begin
      rsp_beat_type got;
      rsp_beat_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.data;
         if (pending_medians.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected response beat %h", got);
         end else begin
            want = pending_medians.pop_front();
            if (got.median !== want.median || got.stored_count !== want.stored_count
                || got.rejected !== want.rejected) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"mismatch: expected med=%0d cnt=%0d rej=%0b",
                            " got med=%0d cnt=%0d rej=%0b"},
                           want.median, want.stored_count, want.rejected,
                           got.median, got.stored_count, got.rejected);
            end
         end
      end
   end

   // field extremes, rounding of even counts, equal samples
   task automatic test_extremes();
      send_sample(16'sh7fff, 1'b1);
      send_sample(16'sh7fff, 1'b0);
      send_sample(-16'sd32768, 1'b1);
      send_sample(-16'sd32768, 1'b0);
      send_sample(16'sh7fff, 1'b0);
      send_sample(-16'sd3, 1'b1);
      send_sample(16'sd0, 1'b0);
      send_sample(16'sd3, 1'b1);
      send_sample(16'sd0, 1'b0);
      send_sample(16'sd5, 1'b1);
      send_sample(16'sd5, 1'b0);
      send_sample(16'sd5, 1'b0);
      send_sample(-16'sd1, 1'b0);
      send_sample(16'sd9, 1'b0);
      send_sample(-16'sd1, 1'b0);
      drain();
   endtask

   // fill the store, hit the full case, then restart while full
   task automatic test_full_store();
      send_sample(16'($urandom), 1'b1);
      for (int i = 1; i < Capacity; i++) send_sample(16'($urandom), 1'b0);
      send_sample(16'sh1234, 1'b0);
      send_sample(-16'sd7, 1'b0);
      drain();
      send_sample(16'sd42, 1'b1);
      send_sample(16'sd40, 1'b0);
      drain();
   endtask

   // random runs, each opened by a restart; some overflow the store
   task automatic test_random_runs();
      int sent;
      int run_len;
      int narrow;
      sent = 0;
      while (sent < 760) begin
         quiet = ($urandom_range(0, 7) == 0);
         sender_gaps = !quiet;
         run_len = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 80) : $urandom_range(1, 20);
         narrow = $urandom_range(0, 2);
         for (int i = 0; i < run_len; i++) begin
            logic signed [15:0] s;
            logic               rs;
            s = (narrow == 0) ? 16'($signed($urandom_range(0, 8)) - 4) : 16'($urandom);
            rs = (i == 0) ? 1'b1 : ($urandom_range(0, 40) == 0);
            send_sample(s, rs);
            sent++;
         end
         if ($urandom_range(0, 9) == 0) drain();
      end
      quiet = 1'b0;
      sender_gaps = 1'b1;
      drain();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_full_store();
      test_random_runs();
      repeat (Capacity * 2) @(posedge clock);
      if (mismatch_count == 0 && pending_medians.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // run limit
   initial begin
      #20000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule : tb
`default_nettype wire
